// ----- rtl/tlca_pkg.sv -----
// Shared constants for the binary-lifting common-ancestor engine.
// No dependencies; used by tlca_ram and tree_lca_binary_lifting.
package tlca_pkg;

	localparam int FIELD_W    = 10;
	localparam int NODES_DEF  = 1024;
	localparam int LEVELS_DEF = 11;

endpackage

// ----- rtl/tlca_ram.sv -----
// Synchronous RAM with one write port and two registered read ports.
// Write-to-read forwarding; addresses below ZERO_BELOW always read as zero.
// Depends on tlca_pkg for default sizes.
module tlca_ram #(
	parameter int DEPTH      = tlca_pkg::NODES_DEF,
	parameter int WIDTH      = tlca_pkg::FIELD_W,
	parameter int ZERO_BELOW = 1,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr0,
	input  logic [AW-1:0]    raddr1,
	output logic [WIDTH-1:0] rdata0,
	output logic [WIDTH-1:0] rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd0_q;
	logic [WIDTH-1:0] rd1_q;
	logic [WIDTH-1:0] fwd_data_q;
	logic             fwd0_q;
	logic             fwd1_q;
	logic             zero0_q;
	logic             zero1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd0_q      <= mem[raddr0];
		rd1_q      <= mem[raddr1];
		fwd_data_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd0_q  <= 1'b0;
			fwd1_q  <= 1'b0;
			zero0_q <= 1'b1;
			zero1_q <= 1'b1;
		end else begin
			fwd0_q  <= we && (waddr == raddr0);
			fwd1_q  <= we && (waddr == raddr1);
			zero0_q <= raddr0 < AW'(ZERO_BELOW);
			zero1_q <= raddr1 < AW'(ZERO_BELOW);
		end
	end

	assign rdata0 = zero0_q ? '0 : (fwd0_q ? fwd_data_q : rd0_q);
	assign rdata1 = zero1_q ? '0 : (fwd1_q ? fwd_data_q : rd1_q);

endmodule

// ----- rtl/tree_lca_binary_lifting.sv -----
// Top level of the binary-lifting lowest-common-ancestor engine.
// Depends on tlca_pkg and on tlca_ram for the depth and jump tables.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  input   | in_valid / in_stall  | kind, node_a, node_b
//  output  | out_valid / out_stall| ancestor
//
// One transaction is handled at a time; in_stall is high while it runs.
// An insert writes the new node's jump levels in turn through the jump RAM, level 0 first.
// A query reads both depths, lifts the deeper node to the other's depth, and ends there when lifting
// meets the other node; the depth-matching lift takes a jump read, then a depth read, per level,
// and the joint lift then uses both jump read ports per level.
// No clearing pass after reset; node 0 reads as zero. A stalled result waits in
// the output register while the next transaction is accepted.
module tree_lca_binary_lifting #(
	parameter int NODES  = tlca_pkg::NODES_DEF,
	parameter int LEVELS = tlca_pkg::LEVELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic [tlca_pkg::FIELD_W-1:0] node_a,
	input  logic [tlca_pkg::FIELD_W-1:0] node_b,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tlca_pkg::FIELD_W-1:0] ancestor
);

	import tlca_pkg::*;

	localparam int NW     = $clog2(NODES);
	localparam int LW     = $clog2(LEVELS);
	localparam int JDEPTH = NODES * LEVELS;
	localparam int JAW    = $clog2(JDEPTH);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_INS   = 4'd1;
	localparam logic [3:0] S_INS_L = 4'd2;
	localparam logic [3:0] S_QR    = 4'd3;
	localparam logic [3:0] S_QD    = 4'd4;
	localparam logic [3:0] S_QLD   = 4'd5;
	localparam logic [3:0] S_QLC   = 4'd6;
	localparam logic [3:0] S_QP    = 4'd7;
	localparam logic [3:0] S_QF    = 4'd8;
	localparam logic [3:0] S_RES   = 4'd9;

	localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

	function automatic logic [NW-1:0] wrap_node(input logic [FIELD_W-1:0] x);
		logic [FIELD_W:0] r;
		r = {1'b0, x};
		for (int k = 7; k >= 0; k--) begin
			if ((NODES << k) < (1 << FIELD_W)) begin
				if (r >= (FIELD_W + 1)'(NODES << k)) begin
					r = r - (FIELD_W + 1)'(NODES << k);
				end
			end
		end
		return NW'(r);
	endfunction

	function automatic logic [JAW-1:0] jaddr(input logic [NW-1:0] n, input logic [LW-1:0] l);
		return JAW'(int'(n) * LEVELS + int'(l));
	endfunction

	logic [3:0]         state_q;
	logic [LW-1:0]      lvl_q;
	logic [NW-1:0]      a_q;
	logic [NW-1:0]      b_q;
	logic [NW-1:0]      up_q;
	logic [NW-1:0]      res_q;
	logic [FIELD_W-1:0] db_q;
	logic [FIELD_W-1:0] anc_q;
	logic               out_valid_q;

	logic               jwe;
	logic [JAW-1:0]     jwaddr;
	logic [NW-1:0]      jwdata;
	logic [JAW-1:0]     jra0;
	logic [JAW-1:0]     jra1;
	logic [NW-1:0]      jrd0;
	logic [NW-1:0]      jrd1;
	logic               dwe;
	logic [NW-1:0]      dwaddr;
	logic [FIELD_W-1:0] dwdata;
	logic [NW-1:0]      dra0;
	logic [NW-1:0]      dra1;
	logic [FIELD_W-1:0] drd0;
	logic [FIELD_W-1:0] drd1;

	logic               swap;
	logic [NW-1:0]      lift_a;
	logic [NW-1:0]      pa;
	logic [NW-1:0]      pb;
	logic [LW-1:0]      lvl_dn;
	logic [NW-1:0]      in_a;

	tlca_ram #(
		.DEPTH(JDEPTH),
		.WIDTH(NW),
		.ZERO_BELOW(LEVELS)
	) u_jump (
		.clk(clk),
		.arst_n(arst_n),
		.we(jwe),
		.waddr(jwaddr),
		.wdata(jwdata),
		.raddr0(jra0),
		.raddr1(jra1),
		.rdata0(jrd0),
		.rdata1(jrd1)
	);

	tlca_ram #(
		.DEPTH(NODES),
		.WIDTH(FIELD_W),
		.ZERO_BELOW(1)
	) u_depth (
		.clk(clk),
		.arst_n(arst_n),
		.we(dwe),
		.waddr(dwaddr),
		.wdata(dwdata),
		.raddr0(dra0),
		.raddr1(dra1),
		.rdata0(drd0),
		.rdata1(drd1)
	);

	assign in_a   = wrap_node(node_a);
	assign swap   = drd0 < drd1;
	assign lift_a = (drd0 >= db_q) ? up_q : a_q;
	assign pa     = (jrd0 != jrd1) ? jrd0 : a_q;
	assign pb     = (jrd0 != jrd1) ? jrd1 : b_q;
	assign lvl_dn = (lvl_q == '0) ? '0 : lvl_q - LW'(1);

	always_comb begin
		jwe    = 1'b0;
		jwaddr = '0;
		jwdata = '0;
		jra0   = '0;
		jra1   = '0;
		dwe    = 1'b0;
		dwaddr = '0;
		dwdata = '0;
		dra0   = '0;
		dra1   = '0;
		unique case (state_q)
			S_INS: begin
				jwe    = 1'b1;
				jwaddr = jaddr(a_q, '0);
				jwdata = b_q;
				jra0   = jaddr(b_q, '0);
				dra0   = b_q;
			end
			S_INS_L: begin
				jwe    = 1'b1;
				jwaddr = jaddr(a_q, lvl_q);
				jwdata = jrd0;
				jra0   = jaddr(jrd0, lvl_q);
				dwe    = (lvl_q == LW'(1));
				dwaddr = a_q;
				dwdata = drd0 + FIELD_W'(1);
			end
			S_QR: begin
				dra0 = a_q;
				dra1 = b_q;
			end
			S_QD: begin
				jra0 = jaddr(swap ? b_q : a_q, LVL_TOP);
			end
			S_QLD: begin
				dra0 = jrd0;
			end
			S_QLC: begin
				jra0 = jaddr(lift_a, (lvl_q == '0) ? LVL_TOP : lvl_dn);
				jra1 = jaddr(b_q, LVL_TOP);
			end
			S_QP: begin
				jra0 = jaddr(pa, lvl_dn);
				jra1 = jaddr(pb, lvl_dn);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lvl_q       <= '0;
			a_q         <= '0;
			b_q         <= '0;
			up_q        <= '0;
			res_q       <= '0;
			db_q        <= '0;
			anc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RES && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						a_q <= in_a;
						b_q <= wrap_node(node_b);
						if (kind) begin
							state_q <= S_QR;
						end else if (in_a != '0) begin
							state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					lvl_q   <= LW'(1);
					state_q <= S_INS_L;
				end
				S_INS_L: begin
					if (lvl_q == LVL_TOP) begin
						state_q <= S_IDLE;
					end else begin
						lvl_q <= lvl_q + LW'(1);
					end
				end
				S_QR: begin
					state_q <= S_QD;
				end
				S_QD: begin
					if (swap) begin
						a_q  <= b_q;
						b_q  <= a_q;
						db_q <= drd0;
					end else begin
						db_q <= drd1;
					end
					lvl_q   <= LVL_TOP;
					state_q <= S_QLD;
				end
				S_QLD: begin
					up_q    <= jrd0;
					state_q <= S_QLC;
				end
				S_QLC: begin
					a_q <= lift_a;
					if (lvl_q == '0) begin
						if (lift_a == b_q) begin
							res_q   <= lift_a;
							state_q <= S_RES;
						end else begin
							lvl_q   <= LVL_TOP;
							state_q <= S_QP;
						end
					end else begin
						lvl_q   <= lvl_dn;
						state_q <= S_QLD;
					end
				end
				S_QP: begin
					a_q <= pa;
					b_q <= pb;
					if (lvl_q == '0) begin
						state_q <= S_QF;
					end else begin
						lvl_q <= lvl_dn;
					end
				end
				S_QF: begin
					res_q   <= jrd0;
					state_q <= S_RES;
				end
				S_RES: begin
					if (!out_valid_q || !out_stall) begin
						anc_q   <= FIELD_W'(res_q);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign ancestor  = anc_q;

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_RES)
		else $error("result raised outside the result state");

	a_no_sentinel_jump_write: assert property (@(posedge clk) disable iff (!arst_n)
		jwe |-> jwaddr >= JAW'(LEVELS))
		else $error("jump write hits the sentinel entries");

	a_no_sentinel_depth_write: assert property (@(posedge clk) disable iff (!arst_n)
		dwe |-> dwaddr != '0)
		else $error("depth write hits the sentinel entry");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> lvl_q <= LVL_TOP)
		else $error("level counter out of range");

endmodule

// ----- dv/lca_check.sv -----
// Operation codes shared by the testbench files, and the checker that watches both channels
// of tree_lca_binary_lifting, predicts every common ancestor and compares it with the result.
// Depends on tlca_pkg for field width, node count and level count.
package lca_tb_pkg;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_QUERY  = 1'b1
	} lca_op_e;

endpackage

module lca_check (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         kind,
	input  logic [tlca_pkg::FIELD_W-1:0] node_a,
	input  logic [tlca_pkg::FIELD_W-1:0] node_b,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [tlca_pkg::FIELD_W-1:0] ancestor,
	output int                           errors,
	output int                           pending,
	output int                           inserts_seen,
	output int                           queries_seen
);

	timeunit 1ns;
	timeprecision 1ps;

	import tlca_pkg::*;
	import lca_tb_pkg::*;

	logic [FIELD_W-1:0] node_depth [NODES_DEF];
	logic [FIELD_W-1:0] lift_to [NODES_DEF][LEVELS_DEF];
	logic [FIELD_W-1:0] ancestor_fifo [$];

	function automatic void attach_node(logic [FIELD_W-1:0] n, logic [FIELD_W-1:0] p);
		if (n == '0) begin
			return;
		end
		node_depth[n] = node_depth[p] + 1'b1;
		lift_to[n][0] = p;
		for (int l = 1; l < LEVELS_DEF; l++) begin
			lift_to[n][l] = lift_to[lift_to[n][l-1]][l-1];
		end
	endfunction

	function automatic logic [FIELD_W-1:0] common_ancestor(logic [FIELD_W-1:0] a,
			logic [FIELD_W-1:0] b);
		logic [FIELD_W-1:0] x, y, up_x, up_y;
		x = a;
		y = b;
		if (node_depth[x] < node_depth[y]) begin
			x = b;
			y = a;
		end
		for (int l = LEVELS_DEF - 1; l >= 0; l--) begin
			up_x = lift_to[x][l];
			if (node_depth[up_x] >= node_depth[y]) begin
				x = up_x;
			end
		end
		if (x == y) begin
			return x;
		end
		for (int l = LEVELS_DEF - 1; l >= 0; l--) begin
			up_x = lift_to[x][l];
			up_y = lift_to[y][l];
			if (up_x != up_y) begin
				x = up_x;
				y = up_y;
			end
		end
		return lift_to[x][0];
	endfunction

	always @(posedge clk) begin
		logic [FIELD_W-1:0] want;
		if (!arst_n) begin
			for (int n = 0; n < NODES_DEF; n++) begin
				node_depth[n] = '0;
				for (int l = 0; l < LEVELS_DEF; l++) begin
					lift_to[n][l] = '0;
				end
			end
			ancestor_fifo.delete();
			errors = 0;
			pending = 0;
			inserts_seen = 0;
			queries_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (ancestor_fifo.size() == 0) begin
					$error("ancestor: no transaction expected, got %0d", ancestor);
					errors++;
				end else begin
					want = ancestor_fifo.pop_front();
					if (ancestor !== want) begin
						$error("ancestor: expected %0d, actual %0d", want, ancestor);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (lca_op_e'(kind) == OP_INSERT) begin
					attach_node(node_a, node_b);
					inserts_seen++;
				end else begin
					ancestor_fifo = {ancestor_fifo, common_ancestor(node_a, node_b)};
					queries_seen++;
				end
			end
			pending = ancestor_fifo.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
// Top of the testbench for tree_lca_binary_lifting: clock, reset, transaction stimulus
// and the verdict. Depends on tlca_pkg, lca_tb_pkg and lca_check.
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import tlca_pkg::*;
	import lca_tb_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               kind;
	logic [FIELD_W-1:0] node_a;
	logic [FIELD_W-1:0] node_b;
	logic               out_valid;
	logic               out_stall;
	logic [FIELD_W-1:0] ancestor;

	int errors, pending, inserts_seen, queries_seen;
	bit idle_on;
	bit placed [NODES_DEF];
	logic [FIELD_W-1:0] roster [$];

	tree_lca_binary_lifting dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.node_a(node_a),
		.node_b(node_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ancestor(ancestor)
	);

	lca_check watch (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.node_a(node_a),
		.node_b(node_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ancestor(ancestor),
		.errors(errors),
		.pending(pending),
		.inserts_seen(inserts_seen),
		.queries_seen(queries_seen)
	);

	initial begin
		clk = 1'b0;
	end

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic send_txn(lca_op_e op, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		node_a <= a;
		node_b <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic add_node(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] p);
		send_txn(OP_INSERT, a, p);
		if (a != '0 && !placed[a]) begin
			placed[a] = 1'b1;
			roster = {roster, a};
		end
	endtask

	function automatic logic [FIELD_W-1:0] any_placed();
		return roster[$urandom_range(0, roster.size() - 1)];
	endfunction

	function automatic logic [FIELD_W-1:0] query_end();
		return ($urandom_range(0, 19) == 0) ? '0 : any_placed();
	endfunction

	// While random gaps are on, each shown result may be stalled at random; once, a long hold lets the block fill.
	initial begin
		int hold, long_hold, taken;
		hold = 0;
		long_hold = 0;
		taken = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				taken++;
				hold = idle_on ? $urandom_range(0, 4) : 0;
				if (taken == 30) begin
					long_hold = 250;
				end
			end
			@(negedge clk);
			if (long_hold > 0) begin
				long_hold--;
				out_stall <= 1'b1;
			end else if (out_valid && hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [FIELD_W-1:0] tip, x;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = OP_INSERT;
		node_a = '0;
		node_b = '0;
		idle_on = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		add_node(10'd1, 10'd0);
		add_node(10'd1023, 10'd1);
		add_node(10'd512, 10'd1023);
		add_node(10'd0, 10'd512);
		add_node(10'd341, 10'd0);
		add_node(10'd682, 10'd341);
		add_node(10'd2, 10'd1);
		send_txn(OP_QUERY, 10'd1023, 10'd512);
		send_txn(OP_QUERY, 10'd512, 10'd2);
		send_txn(OP_QUERY, 10'd512, 10'd682);
		send_txn(OP_QUERY, 10'd0, 10'd1023);
		send_txn(OP_QUERY, 10'd1023, 10'd0);
		send_txn(OP_QUERY, 10'd1, 10'd1);
		send_txn(OP_QUERY, 10'd512, 10'd512);
		add_node(10'd2, 10'd2);
		send_txn(OP_QUERY, 10'd2, 10'd512);
		send_txn(OP_QUERY, 10'd2, 10'd2);
		add_node(10'd1023, 10'd341);
		send_txn(OP_QUERY, 10'd512, 10'd682);
		send_txn(OP_QUERY, 10'd2, 10'd682);

		// Random forest: new and repeated inserts, new roots, and queries on placed nodes and on node 0.
		idle_on = 1'b1;
		for (int i = 0; i < 330; i++) begin
			if ($urandom_range(0, 9) < 6) begin
				if ($urandom_range(0, 49) == 0) begin
					add_node('0, any_placed());
				end else begin
					x = FIELD_W'($urandom_range(1, NODES_DEF - 1));
					add_node(x, ($urandom_range(0, 9) == 0) ? '0 : any_placed());
				end
			end else begin
				send_txn(OP_QUERY, query_end(), query_end());
			end
		end

		// One long chain grows from a placed node, with occasional queries, some of them at its tip.
		tip = any_placed();
		for (int i = 0; i < 450; i++) begin
			idle_on = ((i / 150) % 2) == 1;
			x = FIELD_W'($urandom_range(1, NODES_DEF - 1));
			add_node(x, tip);
			tip = x;
			if ($urandom_range(0, 9) == 0) begin
				send_txn(OP_QUERY, ($urandom_range(0, 1) == 0) ? tip : query_end(),
					query_end());
			end
		end

		in_valid <= 1'b0;
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (45) @(posedge clk);

		$display("Run covered %0d inserts and %0d queries over %0d distinct nodes,",
			inserts_seen, queries_seen, roster.size());
		$display("including self-parent inserts, sentinel queries, a long chain and a long hold.");
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- tree_lca_binary_lifting.f -----
rtl/tlca_pkg.sv
rtl/tlca_ram.sv
rtl/tree_lca_binary_lifting.sv
dv/lca_check.sv
dv/testbench.sv
